// File: rtl/core/fsil_pkg.sv
// Package for the Fibonacci-sized indexed list: sizes, status and operation
// codes, and the control struct broadcast to the storage cells.
// No dependencies.
`default_nettype none
package fsil_pkg;

  localparam int DEPTH    = 64;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CW       = (CNT_W > 7) ? CNT_W : 7;
  localparam int WORD_W   = 32;
  localparam int CAP_W    = 8;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 56;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_POP    = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [CW-1:0]     idx;
    logic [CW-1:0]     cnt;
    logic [WORD_W-1:0] val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/fibonacci_sized_indexed_list.sv
// Fibonacci-sized indexed list, top level: a row of word cells, the count
// and capacity registers, and a two-entry result queue. Uses fsil_pkg,
// fsil_cell and fsil_out_fifo.
// A request's result is registered in the result queue before it is offered.
// Throughput: one request per cycle while the result queue has room; the whole row shifts in that cycle.
// Reset (rst, synchronous, active high) empties the list and the queue and
// sets the capacity pair to (1, 1); the stored words are not cleared.
`default_nettype none
module fibonacci_sized_indexed_list (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // s_tdata, lowest bit up: index[6:0], value[38:7], zero pad [39].
  input  wire logic [fsil_pkg::IN_W-1:0]   s_tdata,
  // s_tuser: func[1:0].
  input  wire logic [1:0]                  s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // m_tdata, lowest bit up: data[31:0], status[33:32], count[40:34],
  // capacity[48:41], zero pad [55:49].
  output logic [fsil_pkg::OUT_W-1:0]       m_tdata
);
  import fsil_pkg::*;

  logic             accept;
  logic             room;
  logic [1:0]       func;
  logic [CW-1:0]    idx_in;
  logic [WORD_W-1:0] value;

  // List state: the count and the Fibonacci capacity pair.
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CAP_W-1:0] cap_cur;
  logic [CAP_W-1:0] cap_cur_next;
  logic [CAP_W-1:0] cap_prev;
  logic [CAP_W-1:0] cap_prev_next;

  cell_ctrl_t       ctrl;
  logic [1:0]       status;
  logic [WORD_W-1:0] data;
  logic [WORD_W-1:0] rd_all;
  logic [OUT_W-1:0] result;

  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] cell_rd   [DEPTH];

  // Wide enough for the capacity sum and for comparing count with it.
  localparam int SW = ((CW > CAP_W) ? CW : CAP_W) + 1;
  logic [SW-1:0]    cnt_w;
  logic [SW-1:0]    cap_sum;
  logic [SW-1:0]    cap_diff;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;
  assign func     = s_tuser;
  assign idx_in   = CW'(s_tdata[6:0]);
  assign value    = s_tdata[38:7];

  assign cnt_w    = SW'(count);
  assign cap_sum  = SW'(cap_cur) + SW'(cap_prev);
  assign cap_diff = SW'(cap_cur) - SW'(cap_prev);

  // Decode the request into the cell control and the new counters. When no
  // request is accepted the cells are told to hold.
  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.idx      = idx_in;
    ctrl.cnt      = count;
    ctrl.val      = value;
    status        = ST_OK;
    count_next    = count;
    cap_cur_next  = cap_cur;
    cap_prev_next = cap_prev;

    if (func == FUNC_PUSH || func == FUNC_INSERT) begin
      if (func == FUNC_PUSH) begin
        ctrl.idx = count;
      end
      if (ctrl.idx > count) begin
        status = ST_RANGE;
      end else if (count >= CW'(DEPTH)) begin
        status = ST_FULL;
      end else begin
        ctrl.op    = OP_INS;
        count_next = count + CW'(1);
        // Adding to a full capacity moves one step up the Fibonacci pair,
        // with the sum held at the largest 8-bit value.
        if (cnt_w >= SW'(cap_cur)) begin
          cap_prev_next = cap_cur;
          cap_cur_next  = (cap_sum > SW'(255)) ? CAP_W'(255) : cap_sum[CAP_W-1:0];
        end
      end
    end else begin
      if (func == FUNC_POP) begin
        if (count == '0) begin
          status = ST_UNDER;
        end else begin
          ctrl.idx = count - CW'(1);
        end
      end else if (ctrl.idx >= count) begin
        status = ST_RANGE;
      end
      if (status == ST_OK) begin
        ctrl.op    = OP_REM;
        count_next = count - CW'(1);
        // Shrinking back one step happens when the count at the start of the
        // removal sits exactly at the difference of the capacity pair.
        if (cap_cur >= cap_prev && cnt_w == cap_diff) begin
          cap_cur_next  = cap_prev;
          cap_prev_next = cap_diff[CAP_W-1:0];
        end
      end
    end

    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // The row of cells. Each cell sees the words of both neighbours; the ends
  // of the row are fed zeros, which are never taken.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_word[i+1];
    end
    fsil_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .pos   (CW'(i)),
      .lower (lower),
      .upper (upper),
      .word  (cell_word[i]),
      .rd    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a non-zero read word, so an OR gathers it.
  always_comb begin
    rd_all = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_all = rd_all | cell_rd[k];
    end
  end

  assign data   = (ctrl.op == OP_REM) ? rd_all : '0;
  assign result = {7'd0, cap_cur_next, count_next[6:0], status, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cap_cur  <= CAP_W'(1);
      cap_prev <= CAP_W'(1);
    end else if (accept) begin
      count    <= count_next;
      cap_cur  <= cap_cur_next;
      cap_prev <= cap_prev_next;
    end
  end

  // The queue lets a new request in while an earlier result is still waiting.
  fsil_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .din      (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// File: rtl/core/fsil_cell.sv
// One storage cell of the list: holds a word and takes a new one from the
// request, its lower neighbour or its upper neighbour. Uses fsil_pkg.
`default_nettype none
module fsil_cell (
  input  wire logic                      clk,
  input  wire fsil_pkg::cell_ctrl_t      ctrl,
  input  wire logic [fsil_pkg::CW-1:0]   pos,
  input  wire logic [fsil_pkg::WORD_W-1:0] lower,
  input  wire logic [fsil_pkg::WORD_W-1:0] upper,
  output logic [fsil_pkg::WORD_W-1:0]    word,
  output logic [fsil_pkg::WORD_W-1:0]    rd
);
  import fsil_pkg::*;

  logic [WORD_W-1:0] word_next;
  logic [CW-1:0]     pos_up;

  assign pos_up = pos + CW'(1);

  always_comb begin
    word_next = word;
    unique case (ctrl.op)
      OP_INS: begin
        if (pos == ctrl.idx) begin
          word_next = ctrl.val;
        end else if (pos > ctrl.idx && pos <= ctrl.cnt) begin
          word_next = lower;
        end
      end
      OP_REM: begin
        if (pos >= ctrl.idx && pos_up < ctrl.cnt) begin
          word_next = upper;
        end
      end
      default: word_next = word;
    endcase
  end

  // Contribution to the read-out OR: only the addressed cell shows its word.
  assign rd = (pos == ctrl.idx) ? word : '0;

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/fsil_out_fifo.sv
// Two-entry result queue between the list logic and the output stream.
// Uses fsil_pkg.
`default_nettype none
module fsil_out_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [fsil_pkg::OUT_W-1:0] din,
  output logic                            room,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [fsil_pkg::OUT_W-1:0]      m_tdata
);
  import fsil_pkg::*;

  logic [OUT_W-1:0] q0;
  logic [OUT_W-1:0] q1;
  logic [1:0]       fill;
  logic             pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fill != 2'd0);
  assign m_tdata  = q0;
  assign room     = (fill != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      unique case (fill)
        2'd0: if (push) begin
          fill <= 2'd1;
        end
        2'd1: if (push && !pop) begin
          fill <= 2'd2;
        end else if (!push && pop) begin
          fill <= 2'd0;
        end
        2'd2: if (pop) begin
          fill <= 2'd1;
        end
        default: fill <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (fill)
      2'd0: if (push) begin
        q0 <= din;
      end
      2'd1: if (push && pop) begin
        q0 <= din;
      end else if (push) begin
        q1 <= din;
      end
      2'd2: if (pop) begin
        q0 <= q1;
      end
      default: q0 <= q0;
    endcase
  end

endmodule
`default_nettype wire

// File: test/fibonacci_sized_indexed_list_tb.sv
// Self-checking testbench for fibonacci_sized_indexed_list: a queue-fed stream
// driver, a result monitor and a cycle-free predictor of the list and its
// capacity pair. Depends on fsil_pkg and the block's RTL only.
`timescale 1ns / 1ps

module fibonacci_sized_indexed_list_tb;
  import fsil_pkg::*;

  // One request as the sender sees it, and one result as it leaves the block.
  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  index;
    logic [31:0] value;
  } list_req_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic [6:0]  count;
    logic [7:0]  capacity;
  } list_resp_t;

  // Ways in which the receiver may hold off results.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int SETTLE_CYCLES   = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic [1:0]        s_tuser  = FUNC_PUSH;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  always #5 clk = ~clk;

  fibonacci_sized_indexed_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Requests not yet taken by the block, and results still owed by it.
  list_req_t  pending_q[$];
  list_resp_t expected_q[$];

  // The predictor's own copy of the list and of the capacity pair.
  logic [31:0] list_words [DEPTH];
  int          list_count = 0;
  int          cap_cur    = 1;
  int          cap_prev   = 1;

  // Occupancy as the stimulus generator believes it will be once every queued
  // request has been applied; it steers indices towards the interesting range.
  int gen_count = 0;

  int fail_count  = 0;
  int n_requests  = 0;
  int n_results   = 0;
  int peak_count  = 0;
  int peak_cap    = 0;
  int status_seen [4];

  // Set by the monitor when a request is taken at a rising edge, and cleared
  // by the driver at the following falling edge.
  bit req_taken = 1'b0;

  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          cycle_ctr  = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  // Applies one request to the predicted list and returns the result that the
  // block should give for it. Grows the capacity pair when a word is added
  // while the count has reached it, and shrinks it when a pop or remove
  // begins with the count at the difference of the pair.
  function automatic list_resp_t apply_request(input list_req_t r);
    list_resp_t res;
    int pos;
    int sum;
    res.data   = '0;
    res.status = ST_OK;
    pos        = int'(r.index);
    if (r.func == FUNC_PUSH || r.func == FUNC_INSERT) begin
      if (r.func == FUNC_PUSH) pos = list_count;
      if (pos > list_count) begin
        res.status = ST_RANGE;
      end else if (list_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (list_count >= cap_cur) begin
          sum      = cap_cur + cap_prev;
          cap_prev = cap_cur;
          cap_cur  = (sum > 255) ? 255 : sum;
        end
        for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = r.value;
        list_count++;
      end
    end else begin
      if (r.func == FUNC_POP) begin
        if (list_count == 0) res.status = ST_UNDER;
        else pos = list_count - 1;
      end else if (pos >= list_count) begin
        res.status = ST_RANGE;
      end
      if (res.status == ST_OK) begin
        res.data = list_words[pos];
        for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
        if (cap_cur >= cap_prev && list_count == cap_cur - cap_prev) begin
          sum      = (cap_cur - cap_prev) & 8'hFF;
          cap_cur  = cap_prev;
          cap_prev = sum;
        end
        list_count--;
      end
    end
    res.count    = 7'(list_count);
    res.capacity = 8'(cap_cur);
    return res;
  endfunction

  // Builds a random request. add_pct is the chance of a push or insert; about
  // one index in seven falls outside the valid range on purpose.
  function automatic list_req_t make_request(input int add_pct);
    list_req_t r;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       r.value = 32'h8000_0000;
        1:       r.value = 32'h7FFF_FFFF;
        2:       r.value = 32'h0000_0000;
        default: r.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      r.value = $urandom;
    end
    if ($urandom_range(1, 100) <= add_pct) begin
      r.func = $urandom_range(0, 1) ? FUNC_INSERT : FUNC_PUSH;
      if (gen_count >= DEPTH || $urandom_range(0, 6) != 0)
        r.index = 7'($urandom_range(0, gen_count));
      else
        r.index = 7'($urandom_range(gen_count + 1, DEPTH));
    end else begin
      r.func = $urandom_range(0, 1) ? FUNC_REMOVE : FUNC_POP;
      if (gen_count > 0 && $urandom_range(0, 6) != 0)
        r.index = 7'($urandom_range(0, gen_count - 1));
      else
        r.index = 7'($urandom_range(gen_count, DEPTH));
    end
    return r;
  endfunction

  // Queues a request for the driver and keeps the generator's occupancy in
  // step with what the block will hold once the request has been applied.
  task automatic enqueue(input list_req_t r);
    if (r.func == FUNC_PUSH || r.func == FUNC_INSERT) begin
      if ((r.func == FUNC_PUSH || r.index <= gen_count) && gen_count < DEPTH)
        gen_count++;
    end else if (r.func == FUNC_POP ? gen_count > 0 : r.index < gen_count) begin
      gen_count--;
    end
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0 || s_tvalid)
      @(posedge clk);
  endtask

  // Driver. Works in bursts separated by random gaps; a request that has been
  // offered is held, unchanged, until the block takes it.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !req_taken)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pending_q[0].value, pending_q[0].index};
        s_tuser  <= pending_q[0].func;
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Receiver. Changes its manner of stalling at random intervals, from never
  // stalling to accepting only the odd result.
  always @(negedge clk) begin
    cycle_ctr++;
    if (stall_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= cycle_ctr[2];
    endcase
  end

  // Monitor. Checks a result against the oldest expectation before the
  // request taken at the same edge is predicted, since a result is registered
  // in the result queue before it is offered.
  always @(posedge clk) begin : monitor
    list_req_t  req;
    list_resp_t want;
    list_resp_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.data     = m_tdata[31:0];
        got.status   = m_tdata[33:32];
        got.count    = m_tdata[40:34];
        got.capacity = m_tdata[48:41];
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: data %0d status %0d",
                 $signed(got.data), got.status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.data !== want.data) begin
            $error("data: expected %0d, got %0d",
                   $signed(want.data), $signed(got.data));
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
          end
          if (got.capacity !== want.capacity) begin
            $error("capacity: expected %0d, got %0d", want.capacity, got.capacity);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req  = pending_q.pop_front();
        want = apply_request(req);
        expected_q.push_back(want);
        status_seen[want.status]++;
        if (int'(want.count) > peak_count) peak_count = int'(want.count);
        if (int'(want.capacity) > peak_cap) peak_cap = int'(want.capacity);
        n_requests++;
        req_taken = 1'b1;
      end
    end
  end

  // Stimulus: a short directed pass, then random segments whose mix of adds
  // and removes swings the list between empty and full.
  initial begin : stimulus
    int add_pcts [5];
    int seg;
    int seg_len;
    int made;
    add_pcts = '{95, 50, 5, 70, 30};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list: pop underflows, remove and insert beyond the end are
    // rejected as out of range.
    enqueue('{FUNC_POP,    7'd0,  32'd0});
    enqueue('{FUNC_REMOVE, 7'd0,  32'd0});
    enqueue('{FUNC_INSERT, 7'd1,  32'h1234_5678});
    // Extreme words; push ignores its index, so the top index bit is set.
    enqueue('{FUNC_PUSH,   7'd64, 32'h7FFF_FFFF});
    enqueue('{FUNC_PUSH,   7'd0,  32'h8000_0000});
    // Insert at the front, then at the end, which appends, then in the middle, then far beyond the end.
    enqueue('{FUNC_INSERT, 7'd0,  32'h0000_0000});
    enqueue('{FUNC_INSERT, 7'd3,  32'hFFFF_FFFF});
    enqueue('{FUNC_INSERT, 7'd2,  32'h5555_5555});
    enqueue('{FUNC_INSERT, 7'd64, 32'hAAAA_AAAA});
    // Remove at the count itself and far beyond it, then front, last, middle.
    enqueue('{FUNC_REMOVE, 7'd5,  32'd0});
    enqueue('{FUNC_REMOVE, 7'd64, 32'd0});
    enqueue('{FUNC_REMOVE, 7'd0,  32'd0});
    enqueue('{FUNC_REMOVE, 7'd3,  32'd0});
    enqueue('{FUNC_REMOVE, 7'd1,  32'd0});
    enqueue('{FUNC_POP,    7'd0,  32'd0});
    enqueue('{FUNC_POP,    7'd0,  32'd0});
    enqueue('{FUNC_POP,    7'd0,  32'd0});
    enqueue('{FUNC_PUSH,   7'd0,  32'hAAAA_AAAA});
    enqueue('{FUNC_POP,    7'd0,  32'd0});

    // Hold the sender back until every directed result has come home.
    wait_drained();

    // The first segment leans hard on adds so that the list fills and the
    // full error is met early; a later drain repeats the pause in mid-run.
    made = 0;
    seg  = 0;
    while (made < RANDOM_REQUESTS) begin
      seg_len = (seg == 0) ? 120 : $urandom_range(40, 160);
      repeat (seg_len) begin
        enqueue(make_request(add_pcts[seg % 5]));
        made++;
      end
      if (seg == 1) wait_drained();
      seg++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d random segments.",
             n_requests, n_results, seg);
    $display("Status ok %0d, range %0d, underflow %0d, full %0d;",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_UNDER],
             status_seen[ST_FULL]);
    $display("peak count %0d, peak capacity %0d.", peak_count, peak_cap);
    if (fail_count == 0) begin
      $display("PASS fibonacci_sized_indexed_list");
    end else begin
      $display("FAIL fibonacci_sized_indexed_list");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d requests pending and %0d results owed.",
             pending_q.size(), expected_q.size());
    $display("FAIL fibonacci_sized_indexed_list");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fsil_pkg.sv
rtl/core/fsil_cell.sv
rtl/core/fsil_out_fifo.sv
rtl/core/fibonacci_sized_indexed_list.sv
test/fibonacci_sized_indexed_list_tb.sv
